// ===== hw/rtl/multiboot_stream_encryptor_core_macros.svh =====
// ----------------------------------------------------------------------------
// Multiboot stream encryptor assertion macros
// Shared concurrent assertion forms for the encryptor core.
// ----------------------------------------------------------------------------
`ifndef MULTIBOOT_STREAM_ENCRYPTOR_CORE_MACROS_SVH
`define MULTIBOOT_STREAM_ENCRYPTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mbse_pkg.sv =====
// ----------------------------------------------------------------------------
// Multiboot stream encryptor package
// Types, constants and helper functions shared by the encryptor modules.
// ----------------------------------------------------------------------------
package mbse_pkg;

    // Field widths.
    localparam int LEN_W = 18;
    localparam int OFF_W = 19;

    // Fixed constants of the upload scheme.
    localparam logic [31:0] SEED_MAGIC   = 32'h6f646573;
    localparam logic [31:0] KEY_MULT     = 32'h6177614b;
    localparam logic [31:0] MASK_MAGIC   = 32'h20796220;
    localparam logic [15:0] CRC_TAPS     = 16'ha1c1;
    localparam logic [15:0] CRC_INIT     = 16'h15a0;
    localparam logic [31:0] KEY_BASE     = 32'h00380000;
    localparam logic [31:0] KEY_HIGHBITS = 32'h80808080;
    localparam logic [31:0] KEY_BIAS     = 32'h00000200;
    localparam logic [OFF_W-1:0] HEADER_END = 19'h000C0;
    localparam logic [31:0] OFFSET_BIAS  = 32'h02000000;
    localparam logic [LEN_W-1:0] LEN_RESET = 18'd192;

    // Input opcodes.
    localparam logic OPC_START = 1'b0;
    localparam logic OPC_DATA  = 1'b1;

    // Output word kinds.
    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_BODY   = 2'd2;
    localparam logic [1:0] KIND_FINAL  = 2'd3;

    // Input and output transaction payloads.
    typedef struct packed {
        logic        opcode;
        logic [31:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic [31:0] wire_word;
        logic [1:0]  word_kind;
        logic        last_word;
    } t_out_item;

    // Classified command passed from front to back.
    typedef enum logic [1:0] {
        CMD_START,
        CMD_HEADER,
        CMD_BODY
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op          op;
        logic             is_last;
        logic [31:0]      word;
        logic [LEN_W-1:0] offset;
    } t_cmd;

    // Command queue status.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC,
        ST_KEY,
        ST_MASK,
        ST_EMIT
    } t_back_state;

    // Key word sent in answer to a start, derived from the payload length.
    function automatic logic [31:0] key_word(input logic [LEN_W-1:0] len);
        logic [31:0] size;
        logic [31:0] a;
        logic [7:0]  sum;
        logic [31:0] b;
        size = ({14'd0, len} - KEY_BIAS) >> 3;
        a    = ((size & 32'h3F80) << 1) | ((size & 32'h4000) << 2)
             | (size & 32'h007F) | KEY_BASE;
        sum  = a[7:0] + a[15:8] + a[23:16];
        b    = {sum, 24'd0} | a | KEY_HIGHBITS;
        return b[9] ? (b ^ SEED_MAGIC) : (b ^ KEY_MULT);
    endfunction

    // One byte of the LSB-first CRC-16.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] crc;
        logic [7:0]  v;
        crc = crc_in;
        v   = data;
        for (int k = 0; k < 8; k++) begin
            if (crc[0] ^ v[0]) begin
                crc = (crc >> 1) ^ CRC_TAPS;
            end else begin
                crc = crc >> 1;
            end
            v = v >> 1;
        end
        return crc;
    endfunction

endpackage

// ===== hw/rtl/multiboot_stream_encryptor_core.sv =====
// ----------------------------------------------------------------------------
// Multiboot stream encryptor core
// Turns a seed and payload words into the masked word stream of an upload.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready / i_in) carries a start
// transaction with the target's seed, then payload words in order. The
// output channel (o_out_valid / i_out_ready / o_out) returns the key word,
// the plain header words, the masked body words and the final checksum
// word, flagged by last_word. The configuration channel writes the payload
// length; it is always ready and should be written only while idle.
// Back end steps: a start or header word is popped and then loaded into
// the output register; a body word is popped, goes through four CRC byte
// steps, one key multiply and one mask, and is loaded; the final word adds
// one more key multiply, mask and load.
// A two-entry command queue lets the front end keep accepting while the
// back end works or the receiver stalls; a stalled receiver holds the
// output register and the back end waits on it.
// Reset clears the upload state, the queue and the output valid, and sets
// the length to 192 bytes. Data words before a start or after the final
// word are accepted and dropped.
// ----------------------------------------------------------------------------
`include "multiboot_stream_encryptor_core_macros.svh"

module multiboot_stream_encryptor_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  mbse_pkg::t_in_item           i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output mbse_pkg::t_out_item          o_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [mbse_pkg::LEN_W-1:0]   i_cfg_data
);
    import mbse_pkg::*;

    logic [LEN_W-1:0] r_length;
    logic             w_push;
    logic             w_pop;
    t_cmd             w_front_cmd;
    t_cmd             w_head_cmd;
    t_q_status        w_q_status;

    // Payload length register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_length <= i_cfg_data;
        end
    end

    // Front end: accept and classify.
    mbse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_length   (r_length),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_cmd      (w_front_cmd)
    );

    // Command queue between the two halves.
    mbse_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_front_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_head_cmd),
        .o_status (w_q_status)
    );

    // Back end: CRC, key, masking and output.
    mbse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_head_cmd),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .i_length    (r_length),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // Queue never takes a command while full nor gives one while empty.
    `MBSE_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, w_push, !w_q_status.full, "queue overflow")
    `MBSE_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, w_pop, !w_q_status.empty, "queue underflow")
    // The last-word flag marks exactly the checksum word.
    `MBSE_ASSERT_IMP(a_last_is_final, i_clk, i_rst_n, o_out_valid, (o_out.last_word == (o_out.word_kind == KIND_FINAL)), "last flag mismatch")

endmodule

// ===== hw/rtl/mbse_front.sv =====
// ----------------------------------------------------------------------------
// Multiboot stream encryptor front end
// Accepts input transactions, tracks the upload offset and classifies words.
// ----------------------------------------------------------------------------
module mbse_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  mbse_pkg::t_in_item           i_in,
    input  logic [mbse_pkg::LEN_W-1:0]   i_length,
    input  mbse_pkg::t_q_status          i_q_status,
    output logic                         o_push,
    output mbse_pkg::t_cmd               o_cmd
);
    import mbse_pkg::*;

    logic             r_active;
    logic [LEN_W-1:0] r_off;
    logic             accept;
    logic [OFF_W-1:0] next_off;
    logic             is_last;

    // Accept whenever the queue has room; ignored data is simply dropped.
    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;

    // Offset after this word and the end-of-upload test.
    assign next_off = {1'b0, r_off} + OFF_W'(4);
    assign is_last  = (next_off >= HEADER_END) && (next_off >= {1'b0, i_length});

    // Classify the accepted word into a command.
    always_comb begin
        o_cmd.word = i_in.data_word;
        if (i_in.opcode == OPC_START) begin
            o_cmd.op      = CMD_START;
            o_cmd.is_last = 1'b0;
            o_cmd.offset  = '0;
        end else begin
            o_cmd.op      = ({1'b0, r_off} < HEADER_END) ? CMD_HEADER : CMD_BODY;
            o_cmd.is_last = is_last;
            o_cmd.offset  = r_off;
        end
        o_push = accept && ((i_in.opcode == OPC_START) || r_active);
    end

    // Upload progress tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_off    <= '0;
        end else if (accept) begin
            if (i_in.opcode == OPC_START) begin
                r_active <= 1'b1;
                r_off    <= '0;
            end else if (r_active) begin
                r_off <= next_off[LEN_W-1:0];
                if (is_last) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/mbse_queue.sv =====
// ----------------------------------------------------------------------------
// Multiboot stream encryptor command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mbse_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mbse_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output mbse_pkg::t_cmd       o_cmd,
    output mbse_pkg::t_q_status  o_status
);
    import mbse_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_cmd          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/mbse_back.sv =====
// ----------------------------------------------------------------------------
// Multiboot stream encryptor back end
// Runs the CRC, advances the session key, masks words and drives the output.
// ----------------------------------------------------------------------------
module mbse_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mbse_pkg::t_cmd               i_cmd,
    input  mbse_pkg::t_q_status          i_q_status,
    output logic                         o_pop,
    input  logic [mbse_pkg::LEN_W-1:0]   i_length,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output mbse_pkg::t_out_item          o_out
);
    import mbse_pkg::*;

    t_back_state      r_state;
    t_back_state      n_state;
    logic [31:0]      r_word;
    logic [OFF_W-1:0] r_off;
    logic [1:0]       r_kind;
    logic             r_more;
    logic [31:0]      r_key;
    logic [15:0]      r_crc;
    logic [1:0]       r_cnt;
    t_out_item        r_res;
    logic             r_out_valid;
    t_out_item        r_out;
    logic             out_free;
    logic             out_load;
    logic [31:0]      off_term;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_free    = !r_out_valid || i_out_ready;

    // Offset term of the mask: the negated biased offset.
    assign off_term = 32'd0 - ({13'd0, r_off} + OFFSET_BIAS);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = (i_cmd.op == CMD_BODY) ? ST_CRC : ST_EMIT;
                end
            end
            ST_CRC: begin
                if (r_cnt == 2'd3) begin
                    n_state = ST_KEY;
                end
            end
            ST_KEY: begin
                n_state = ST_MASK;
            end
            ST_MASK: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = r_more ? ST_KEY : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_pop    = (r_state == ST_IDLE) && !i_q_status.empty;
        out_load = (r_state == ST_EMIT) && out_free;
    end

    // Control state, key, CRC and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_key       <= '0;
            r_crc       <= CRC_INIT;
            r_more      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        // The front end never flags a start as last.
                        r_cnt  <= '0;
                        r_more <= i_cmd.is_last;
                        if (i_cmd.op == CMD_START) begin
                            r_key  <= i_cmd.word ^ SEED_MAGIC;
                            r_crc  <= CRC_INIT;
                        end
                    end
                end
                ST_CRC: begin
                    r_crc <= crc_byte(r_crc, r_word[{r_cnt, 3'b000} +: 8]);
                    r_cnt <= r_cnt + 2'd1;
                end
                ST_KEY: begin
                    r_key <= r_key * KEY_MULT + 32'd1;
                end
                ST_EMIT: begin
                    if (out_load && r_more) begin
                        r_more <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Word, offset and result payload registers.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    r_word <= i_cmd.word;
                    r_off  <= {1'b0, i_cmd.offset};
                    r_kind <= KIND_BODY;
                    case (i_cmd.op)
                        CMD_START: begin
                            r_res <= '{wire_word: key_word(i_length),
                                       word_kind: KIND_KEY, last_word: 1'b0};
                        end
                        CMD_HEADER: begin
                            r_res <= '{wire_word: i_cmd.word,
                                       word_kind: KIND_HEADER, last_word: 1'b0};
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MASK: begin
                r_res <= '{wire_word: r_word ^ r_key ^ off_term ^ MASK_MAGIC,
                           word_kind: r_kind, last_word: (r_kind == KIND_FINAL)};
            end
            ST_EMIT: begin
                // Load the checksum word once the last payload word has gone out.
                if (out_load && r_more) begin
                    r_word <= {i_length[15:0], r_crc};
                    r_off  <= r_off + OFF_W'(4);
                    r_kind <= KIND_FINAL;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
